>>> design/vetc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector element type coercion package
// Shared types, type codes and register addresses for the coercion core.
// ----------------------------------------------------------------------------
`default_nettype none

package vetc_pkg;

    localparam logic [1:0] TYPE_INT  = 2'd0;
    localparam logic [1:0] TYPE_LGL  = 2'd1;
    localparam logic [1:0] TYPE_DBL  = 2'd2;
    localparam logic [1:0] TYPE_NONE = 2'd3;

    localparam logic [2:0] REG_SOURCE_TYPE = 3'd0;
    localparam logic [2:0] REG_TARGET_TYPE = 3'd1;
    localparam logic [2:0] REG_NA_INTEGER  = 3'd2;
    localparam logic [2:0] REG_NA_LOGICAL  = 3'd3;
    localparam logic [2:0] REG_NA_DOUBLE   = 3'd4;

    typedef struct packed {
        logic [63:0] element_bits;
        logic        last_element;
    } in_item_t;

    typedef struct packed {
        logic [63:0] result_bits;
        logic        result_is_na;
        logic        any_na_seen;
        logic        result_last;
    } out_item_t;

    typedef enum logic [2:0] {
        OP_ZERO    = 3'b000,
        OP_PASS    = 3'b001,
        OP_TO_DBL  = 3'b010,
        OP_TO_LGL  = 3'b011,
        OP_DBL_INT = 3'b100,
        OP_DBL_LGL = 3'b101
    } op_t;

    // Classified item handed from the front end to the back end.
    typedef struct packed {
        op_t         op;
        logic [63:0] value;
        logic        is_na;
        logic        last;
    } cls_item_t;

    typedef struct packed {
        logic [31:0] na_integer;
        logic [31:0] na_logical;
        logic [63:0] na_double;
    } na_cfg_t;

endpackage

`default_nettype wire

>>> design/vetc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coercion front end
// Accepts elements, classifies the conversion and detects missing-value markers.
// ----------------------------------------------------------------------------
`default_nettype none

module vetc_front import vetc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    input  wire logic [1:0] source_type,
    input  wire logic [1:0] target_type,
    input  wire na_cfg_t   na_cfg,
    output logic           f_valid,
    input  wire logic      f_ready,
    output cls_item_t      f_data
);

    logic      valid_reg;
    cls_item_t data_reg;
    cls_item_t data_next;
    logic [31:0] lo;
    logic [31:0] marker;

    assign s_ready = !valid_reg || f_ready;
    assign f_valid = valid_reg;
    assign f_data  = data_reg;
    assign lo      = s_data.element_bits[31:0];
    assign marker  = (source_type == TYPE_INT) ? na_cfg.na_integer : na_cfg.na_logical;

    always_comb begin
        data_next.last  = s_data.last_element;
        data_next.value = {32'd0, lo};
        data_next.is_na = (lo == marker);
        data_next.op    = OP_ZERO;
        if (source_type == TYPE_NONE || target_type == TYPE_NONE) begin
            data_next.is_na = 1'b0;
        end else if (source_type == target_type) begin
            data_next.op = OP_PASS;
            if (source_type == TYPE_DBL) begin
                data_next.value = s_data.element_bits;
                data_next.is_na = (s_data.element_bits == na_cfg.na_double);
            end
        end else if (source_type != TYPE_DBL) begin
            case (target_type)
                TYPE_DBL: data_next.op = OP_TO_DBL;
                TYPE_LGL: data_next.op = OP_TO_LGL;
                default: begin
                    data_next.op = OP_PASS;
                    if (lo == marker) begin
                        data_next.value = {32'd0, na_cfg.na_integer};
                    end
                end
            endcase
        end else begin
            data_next.value = s_data.element_bits;
            data_next.is_na = 1'b0;
            data_next.op    = (target_type == TYPE_INT) ? OP_DBL_INT : OP_DBL_LGL;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> design/vetc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coercion decoupling queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module vetc_fifo import vetc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      w_valid,
    output logic           w_ready,
    input  wire cls_item_t w_data,
    output logic           r_valid,
    input  wire logic      r_ready,
    output cls_item_t      r_data
);

    cls_item_t  mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] count_reg;
    logic       do_w;
    logic       do_r;

    assign w_ready = (count_reg != 2'd2);
    assign r_valid = (count_reg != 2'd0);
    assign r_data  = mem_reg[rptr_reg];
    assign do_w    = w_valid && w_ready;
    assign do_r    = r_valid && r_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= 1'b0;
            rptr_reg  <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            if (do_w) begin
                wptr_reg <= !wptr_reg;
            end
            if (do_r) begin
                rptr_reg <= !rptr_reg;
            end
            count_reg <= count_reg + {1'b0, do_w} - {1'b0, do_r};
        end
        if (do_w) begin
            mem_reg[wptr_reg] <= w_data;
        end
    end

endmodule

`default_nettype wire

>>> design/vetc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Coercion back end
// Performs the numeric conversion and keeps the sticky missing-value flag.
// ----------------------------------------------------------------------------
`default_nettype none

module vetc_back import vetc_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      q_valid,
    output logic           q_ready,
    input  wire cls_item_t q_data,
    input  wire na_cfg_t   na_cfg,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic        valid_reg;
    out_item_t   data_reg;
    out_item_t   data_next;
    logic        acc_reg;
    logic        acc_next;
    logic        take;
    logic [31:0] lo;
    logic [31:0] mag;
    logic [4:0]  msb;
    logic [10:0] exp_i;
    logic [51:0] man_i;
    logic [63:0] dbl_i;
    logic [10:0] exp_d;
    logic        sgn_d;
    logic        is_nan;
    logic        is_zero;
    logic        in_range;
    logic [52:0] sig;
    logic [5:0]  sh;
    logic        frac_nz;
    logic [31:0] tmag;
    logic [31:0] tval;

    assign q_ready = !valid_reg || m_ready;
    assign take    = q_valid && q_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;
    assign lo      = q_data.value[31:0];

    always_comb begin
        mag = lo[31] ? (~lo + 32'd1) : lo;
        msb = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (mag[i]) begin
                msb = 5'(i);
            end
        end
        exp_i = 11'd1023 + {6'd0, msb};
        man_i = {20'd0, mag << (6'd32 - {1'b0, msb})};
        man_i = man_i << 20;
        dbl_i = (mag == 32'd0) ? 64'd0 : {lo[31], exp_i, man_i};
    end

    always_comb begin
        sgn_d   = q_data.value[63];
        exp_d   = q_data.value[62:52];
        is_nan  = (exp_d == 11'h7FF) && (q_data.value[51:0] != 52'd0);
        is_zero = (q_data.value[62:0] == 63'd0);
        sig     = {1'b1, q_data.value[51:0]};
        sh      = 6'd0;
        frac_nz = 1'b0;
        if (exp_d < 11'd1023) begin
            tmag = 32'd0;
        end else if (exp_d > 11'd1054) begin
            tmag = 32'hFFFFFFFF;
        end else begin
            sh      = 6'(11'd1075 - exp_d);
            tmag    = 32'(sig >> sh);
            frac_nz = ((sig & ~({53{1'b1}} << sh)) != 53'd0);
        end
        if (exp_d > 11'd1054) begin
            in_range = 1'b0;
        end else if (sgn_d) begin
            in_range = (tmag < 32'h80000000) || ((tmag == 32'h80000000) && !frac_nz);
        end else begin
            in_range = (tmag < 32'h7FFFFFFF) || ((tmag == 32'h7FFFFFFF) && !frac_nz);
        end
        tval = sgn_d ? (~tmag + 32'd1) : tmag;
    end

    always_comb begin
        acc_next              = acc_reg;
        data_next.result_last = q_data.last;
        data_next.result_is_na = q_data.is_na;
        data_next.result_bits = 64'd0;
        case (q_data.op)
            OP_PASS: begin
                data_next.result_bits = q_data.value;
            end
            OP_TO_DBL: begin
                data_next.result_bits = q_data.is_na ? na_cfg.na_double : dbl_i;
            end
            OP_TO_LGL: begin
                data_next.result_bits = q_data.is_na ? {32'd0, na_cfg.na_logical}
                                                     : {63'd0, lo != 32'd0};
            end
            OP_DBL_INT: begin
                if (is_nan || !in_range) begin
                    data_next.result_is_na = 1'b1;
                    data_next.result_bits  = {32'd0, na_cfg.na_integer};
                    acc_next               = 1'b1;
                end else begin
                    data_next.result_bits = {32'd0, tval};
                end
            end
            OP_DBL_LGL: begin
                data_next.result_is_na = is_nan;
                data_next.result_bits  = is_nan ? {32'd0, na_cfg.na_logical}
                                                : {63'd0, !is_zero};
            end
            default: begin
                data_next.result_is_na = 1'b0;
            end
        endcase
        data_next.any_na_seen = acc_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            acc_reg   <= 1'b0;
        end else begin
            if (q_ready) begin
                valid_reg <= q_valid;
            end
            if (take) begin
                acc_reg <= acc_next && !q_data.last;
            end
        end
        if (take) begin
            data_reg <= data_next;
        end
    end

endmodule

`default_nettype wire

>>> design/vector_element_type_coercion_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vector element type coercion core
// Streams vector elements between integer, logical and double types.
// ----------------------------------------------------------------------------
// One element is taken per cycle while s_ready is high; its result passes
// through the front end register, a two-entry queue and the back end output
// register, three stages in all. Each side stalls on its own.
`default_nettype none

module vector_element_type_coercion_core import vetc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire in_item_t    s_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output out_item_t        m_data
);

    logic [1:0] source_type_reg;
    logic [1:0] target_type_reg;
    na_cfg_t    na_cfg_reg;
    logic [2:0] reg_idx;
    logic       f_valid;
    logic       f_ready;
    cls_item_t  f_data;
    logic       q_valid;
    logic       q_ready;
    cls_item_t  q_data;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            source_type_reg       <= TYPE_INT;
            target_type_reg       <= TYPE_DBL;
            na_cfg_reg.na_integer <= 32'h80000000;
            na_cfg_reg.na_logical <= 32'h80000000;
            na_cfg_reg.na_double  <= 64'h7FF00000000007A2;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_SOURCE_TYPE: source_type_reg       <= pwdata[1:0];
                REG_TARGET_TYPE: target_type_reg       <= pwdata[1:0];
                REG_NA_INTEGER:  na_cfg_reg.na_integer <= pwdata[31:0];
                REG_NA_LOGICAL:  na_cfg_reg.na_logical <= pwdata[31:0];
                REG_NA_DOUBLE:   na_cfg_reg.na_double  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SOURCE_TYPE: prdata = {62'd0, source_type_reg};
            REG_TARGET_TYPE: prdata = {62'd0, target_type_reg};
            REG_NA_INTEGER:  prdata = {32'd0, na_cfg_reg.na_integer};
            REG_NA_LOGICAL:  prdata = {32'd0, na_cfg_reg.na_logical};
            REG_NA_DOUBLE:   prdata = na_cfg_reg.na_double;
            default:         prdata = 64'd0;
        endcase
    end

    vetc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .source_type (source_type_reg),
        .target_type (target_type_reg),
        .na_cfg      (na_cfg_reg),
        .f_valid     (f_valid),
        .f_ready     (f_ready),
        .f_data      (f_data)
    );

    vetc_fifo u_fifo (
        .aclk    (aclk),
        .aresetn (aresetn),
        .w_valid (f_valid),
        .w_ready (f_ready),
        .w_data  (f_data),
        .r_valid (q_valid),
        .r_ready (q_ready),
        .r_data  (q_data)
    );

    vetc_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .na_cfg  (na_cfg_reg),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire
